// File: rtl/jse_pkg.sv
package jse_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 3;

  localparam logic [ByteW-1:0] CtrlLimit   = 8'd31;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChDquote    = 8'h22;
  localparam logic [ByteW-1:0] ChSquote    = 8'h27;
  localparam logic [ByteW-1:0] ChBs        = 8'h08;
  localparam logic [ByteW-1:0] ChFf        = 8'h0C;
  localparam logic [ByteW-1:0] ChLf        = 8'h0A;
  localparam logic [ByteW-1:0] ChCr        = 8'h0D;
  localparam logic [ByteW-1:0] ChTab       = 8'h09;
  localparam logic [ByteW-1:0] ChLowerU    = 8'h75;
  localparam logic [ByteW-1:0] ChZero      = 8'h30;

  localparam logic [IdxW-1:0] LastPlain   = 3'd0;
  localparam logic [IdxW-1:0] LastPair    = 3'd1;
  localparam logic [IdxW-1:0] LastUnicode = 3'd5;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_PAIR,
    KIND_UNICODE
  } kind_e;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [IdxW-1:0]  idx_t;

  function automatic kind_e classify(input byte_t c, input logic apos_sel);
    byte_t quote;
    quote = apos_sel ? ChSquote : ChDquote;
    if (c == ChBackslash || c == quote) begin
      return KIND_PAIR;
    end else if (c > CtrlLimit) begin
      return KIND_PLAIN;
    end else if (c == ChBs || c == ChFf || c == ChLf || c == ChCr || c == ChTab) begin
      return KIND_PAIR;
    end else begin
      return KIND_UNICODE;
    end
  endfunction

  function automatic idx_t last_idx(input kind_e kind);
    idx_t r;
    unique case (kind)
      KIND_PLAIN:   r = LastPlain;
      KIND_PAIR:    r = LastPair;
      KIND_UNICODE: r = LastUnicode;
      default:      r = LastPlain;
    endcase
    return r;
  endfunction

  function automatic byte_t hex_digit(input logic [3:0] nib);
    byte_t r;
    if (nib < 4'd10) begin
      r = ChZero + {4'd0, nib};
    end else begin
      r = 8'h61 + {4'd0, nib - 4'd10};
    end
    return r;
  endfunction

  function automatic byte_t pair_second(input byte_t c);
    byte_t r;
    unique case (c)
      ChBs:    r = 8'h62;
      ChFf:    r = 8'h66;
      ChLf:    r = 8'h6E;
      ChCr:    r = 8'h72;
      ChTab:   r = 8'h74;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic byte_t esc_byte(input kind_e kind, input byte_t c, input idx_t idx);
    byte_t r;
    r = c;
    if (kind == KIND_PLAIN) begin
      r = c;
    end else if (idx == '0) begin
      r = ChBackslash;
    end else if (kind == KIND_PAIR) begin
      r = pair_second(c);
    end else begin
      unique case (idx)
        3'd1:    r = ChLowerU;
        3'd2:    r = ChZero;
        3'd3:    r = ChZero;
        3'd4:    r = hex_digit(c[7:4]);
        3'd5:    r = hex_digit(c[3:0]);
        default: r = ChZero;
      endcase
    end
    return r;
  endfunction

endpackage

// File: rtl/jse_in_if.sv
interface jse_in_if;
  logic                    valid;
  logic                    ready;
  logic [jse_pkg::ByteW-1:0] in_byte;
  logic                    string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

// File: rtl/jse_out_if.sv
interface jse_out_if;
  logic                    valid;
  logic                    ready;
  logic [jse_pkg::ByteW-1:0] out_byte;
  logic                    run_last;
  logic                    string_last;

  modport source (output valid, output out_byte, output run_last, output string_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_last,
                output ready);
endinterface

// File: rtl/json_string_escaper_unit.sv
// Each accepted item is held in the item register; a new item is taken as its last byte is emitted.
// One output byte per cycle while out_o.ready does not stall the output; a plain byte gives one
// byte, a two-byte escape two bytes and a \u escape six, set by the escape length of the held item.
// Reset (rst_ni low, asynchronous) empties the item and output registers and clears
// the quote mode to 0.
module json_string_escaper_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_data_i,
  jse_in_if.sink    in_i,
  jse_out_if.source out_o
);
  import jse_pkg::*;

  logic  mode_q;
  logic  hold_q;
  byte_t byte_q;
  logic  end_q;
  idx_t  idx_q, idx_d;
  logic  ov_q;
  byte_t ob_q;
  logic  orl_q;
  logic  osl_q;

  kind_e kind;
  idx_t  last;
  logic  advance;
  logic  emit;
  logic  run_done;
  logic  in_acc;

  assign kind     = classify(byte_q, mode_q);
  assign last     = last_idx(kind);
  assign advance  = !ov_q || out_o.ready;
  assign emit     = hold_q && advance;
  assign run_done = (idx_q == last);
  assign in_i.ready = !hold_q || (emit && run_done);
  assign in_acc   = in_i.valid && in_i.ready;
  assign idx_d    = in_acc ? '0 : ((emit && !run_done) ? idx_q + 3'd1 : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      idx_q <= idx_d;
      if (in_acc) begin
        hold_q <= 1'b1;
      end else if (emit && run_done) begin
        hold_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= in_i.in_byte;
      end_q  <= in_i.string_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (advance) begin
      ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ob_q  <= esc_byte(kind, byte_q, idx_q);
      orl_q <= run_done;
      osl_q <= run_done && end_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_byte    = ob_q;
  assign out_o.run_last    = orl_q;
  assign out_o.string_last = osl_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> (idx_q <= last))
    else $error("escape index past run end");

  a_str_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && osl_q) |-> orl_q)
    else $error("string_last without run_last");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q && !emit) |=> (hold_q && $stable(byte_q) && $stable(idx_q)))
    else $error("held item changed while stalled");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (hold_q && idx_q == '0))
    else $error("accepted item not loaded");

  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> ov_q)
    else $error("emitted byte lost");

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jse_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxGap     = 16;
  localparam byte_t ChLowerA = 8'h61;

  typedef struct packed {
    byte_t out_byte;
    logic  run_last;
    logic  string_last;
  } esc_byte_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;

  jse_in_if  in_bus ();
  jse_out_if out_bus ();

  json_string_escaper_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  esc_byte_t escaped_q[$];
  logic      apos_mode;
  logic      tx_idle_en;
  logic      rx_idle_en;
  int        mismatches;
  int        cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic byte_t nib_char(input logic [3:0] n);
    byte_t r;
    if (n < 4'd10) begin
      r = ChZero + byte_t'(n);
    end else begin
      r = ChLowerA + byte_t'(n) - 8'd10;
    end
    return r;
  endfunction

  function automatic void push_esc(input byte_t b, input logic run_end, input logic str_end);
    esc_byte_t e;
    e.out_byte    = b;
    e.run_last    = run_end;
    e.string_last = run_end & str_end;
    escaped_q.push_back(e);
  endfunction

  function automatic void predict_escape(input byte_t c, input logic str_end);
    byte_t quote;
    byte_t second;
    quote = apos_mode ? ChSquote : ChDquote;
    if (c > CtrlLimit && c != ChBackslash && c != quote) begin
      push_esc(c, 1'b1, str_end);
    end else begin
      push_esc(ChBackslash, 1'b0, str_end);
      second = 8'h00;
      case (c)
        ChBackslash, ChSquote, ChDquote: second = c;
        ChBs:  second = "b";
        ChFf:  second = "f";
        ChLf:  second = "n";
        ChCr:  second = "r";
        ChTab: second = "t";
        default: begin
          push_esc(ChLowerU, 1'b0, str_end);
          push_esc(ChZero, 1'b0, str_end);
          push_esc(ChZero, 1'b0, str_end);
          push_esc(nib_char(c[7:4]), 1'b0, str_end);
          push_esc(nib_char(c[3:0]), 1'b1, str_end);
        end
      endcase
      if (second != 8'h00) begin
        push_esc(second, 1'b1, str_end);
      end
    end
  endfunction

  function automatic byte_t pick_char();
    byte_t c;
    case ($urandom_range(0, 9))
      0, 1: c = byte_t'($urandom_range(1, 31));
      2: begin
        case ($urandom_range(0, 2))
          0:       c = ChBackslash;
          1:       c = ChDquote;
          default: c = ChSquote;
        endcase
      end
      3:       c = byte_t'($urandom_range(127, 255));
      4:       c = byte_t'($urandom_range(1, 255));
      default: c = byte_t'($urandom_range(32, 126));
    endcase
    return c;
  endfunction

  // valid stays high after acceptance; the next send or a drain moves it
  task automatic send_char(input byte_t c, input logic str_end);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MaxGap) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid      <= 1'b1;
    in_bus.in_byte    <= c;
    in_bus.string_end <= str_end;
    do @(posedge clk); while (!in_bus.ready);
    predict_escape(c, str_end);
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_quote_mode(input logic v);
    drain();
    repeat (2) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    apos_mode = v;
  endtask

  task automatic send_string(input int n);
    for (int i = 0; i < n; i++) begin
      send_char(pick_char(), i == n - 1);
    end
  endtask

  task automatic run_text(input int target, input logic pause_mid);
    int sent;
    int len;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < target) begin
      len = $urandom_range(1, 12);
      if (len > target - sent) begin
        len = target - sent;
      end
      send_string(len);
      sent += len;
      if (pause_mid && !paused && sent >= target / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
  endtask

  task automatic test_plain_bytes();
    byte_t chars[$] = '{8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF, ChSquote, 8'h41};
    foreach (chars[i]) begin
      send_char(chars[i], i == chars.size() - 1);
    end
    drain();
  endtask

  task automatic test_escapes();
    byte_t chars[$] = '{ChBackslash, ChDquote, ChBs, ChFf, ChLf, ChCr, ChTab,
                        8'h01, 8'h0B, 8'h1F, 8'h1A, 8'h10};
    foreach (chars[i]) begin
      send_char(chars[i], i == chars.size() - 1);
    end
    drain();
  endtask

  task automatic test_quote_mode();
    set_quote_mode(1'b1);
    send_char(ChSquote, 1'b0);
    send_char(ChDquote, 1'b0);
    send_char(ChBackslash, 1'b0);
    send_char(ChLf, 1'b1);
    set_quote_mode(1'b0);
  endtask

  task automatic test_random_text();
    run_text(50, 1'b0);
    set_quote_mode(1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_text(50, 1'b0);
    tx_idle_en = 1'b1;
    run_text(50, 1'b1);
    set_quote_mode(1'b0);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    run_text(50, 1'b0);
    tx_idle_en = 1'b1;
  endtask

  initial begin
    int stall;
    esc_byte_t exp_b;
    out_bus.ready = 1'b0;
    forever begin
      stall = rx_idle_en ? $urandom_range(0, MaxGap) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      if (escaped_q.size() == 0) begin
        $error("unexpected output byte %h", out_bus.out_byte);
        mismatches++;
      end else begin
        exp_b = escaped_q.pop_front();
        if (out_bus.out_byte !== exp_b.out_byte) begin
          $error("out_byte: expected %h, got %h", exp_b.out_byte, out_bus.out_byte);
          mismatches++;
        end
        if (out_bus.run_last !== exp_b.run_last) begin
          $error("run_last: expected %b, got %b", exp_b.run_last, out_bus.run_last);
          mismatches++;
        end
        if (out_bus.string_last !== exp_b.string_last) begin
          $error("string_last: expected %b, got %b", exp_b.string_last,
                 out_bus.string_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.in_byte    = '0;
    in_bus.string_end = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = 1'b0;
    rst_n             = 1'b0;
    apos_mode         = 1'b0;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    mismatches        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_bytes();
    test_escapes();
    test_quote_mode();
    test_random_text();

    drain();
    rx_idle_en = 1'b0;
    repeat (40) @(posedge clk);
    if (escaped_q.size() == 0 && mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/jse_pkg.sv
rtl/jse_in_if.sv
rtl/jse_out_if.sv
rtl/json_string_escaper_unit.sv
tb/testbench.sv
